// ----- hw/rtl/smx_pkg.sv -----
// Package for the softmax normalizer: widths, sizes and the base-2 fraction table.
// No dependencies.
`default_nettype none
package smx_pkg;
   localparam int MaxEntries = 32;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam int LogitW = 16;
   localparam int ProbW = 16;
   localparam int TermW = 17;
   localparam int SumW = 22;
   localparam logic [SumW-1:0] SumLimit = {SumW{1'b1}};
   localparam logic [15:0] Log2eQ15 = 16'd47274;
   localparam int QuotW = 17;

   typedef struct packed {
      logic load;
      logic clear;
      logic div_start;
      logic [IdxW-1:0] idx;
   } ctl_type;

   typedef struct packed {
      logic [CntW-1:0] count;
      logic div_done;
   } stat_type;

   function automatic logic [TermW-1:0] pow2_frac(input logic [3:0] f);
      logic [TermW-1:0] r;
      case (f)
         4'd0: r = 17'd65536;  4'd1: r = 17'd62757;
         4'd2: r = 17'd60097;  4'd3: r = 17'd57549;
         4'd4: r = 17'd55109;  4'd5: r = 17'd52773;
         4'd6: r = 17'd50535;  4'd7: r = 17'd48393;
         4'd8: r = 17'd46341;  4'd9: r = 17'd44376;
         4'd10: r = 17'd42495; 4'd11: r = 17'd40693;
         4'd12: r = 17'd38968; 4'd13: r = 17'd37315;
         4'd14: r = 17'd35734; 4'd15: r = 17'd34219;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/smx_if.sv -----
// Valid/ready channel interfaces for logit and probability beats.
// Depends on nothing.
`default_nettype none
interface smx_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] logit;
   logic last_logit;
   modport source (output valid, logit, last_logit, input ready);
   modport sink (input valid, logit, last_logit, output ready);
endinterface

interface smx_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] probability;
   logic last_probability;
   modport source (output valid, probability, last_probability, input ready);
   modport sink (input valid, probability, last_probability, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/smx_datapath.sv -----
// Softmax datapath: logit store, running max, exponent terms, sum, serial divider.
// Depends on smx_pkg.
`default_nettype none
module smx_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire smx_pkg::ctl_type ctl,
   input  wire logic signed [smx_pkg::LogitW-1:0] logit,
   input  wire logic exp_valid,
   output smx_pkg::stat_type stat,
   output logic [smx_pkg::ProbW-1:0] quotient
);
   logic signed [smx_pkg::LogitW-1:0] logit_mem [smx_pkg::MaxEntries];
   logic [smx_pkg::TermW-1:0] term_mem [smx_pkg::MaxEntries];
   logic signed [smx_pkg::LogitW-1:0] max_ff, max_in, rd_logit_ff;
   logic [smx_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [smx_pkg::SumW-1:0] sum_ff, sum_in;
   logic [smx_pkg::LogitW-1:0] t_ff;
   logic [31:0] prod_ff;
   logic [smx_pkg::TermW-1:0] term_c, rd_term_ff;
   logic [smx_pkg::IdxW-1:0] widx_ff, widx2_ff, widx3_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic [12:0] v_c;
   logic [22:0] sum_add;
   logic [smx_pkg::SumW:0] rem_ff, rem_in, rem_sh;
   logic [smx_pkg::QuotW-1:0] q_ff, q_in;
   logic [38:0] num_ff, num_in;
   logic [5:0] bit_ff, bit_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      v_c = 13'((32'(prod_ff) + 32'h40000) >> 19);
      if (v_c[12:4] >= 9'd32) term_c = '0;
      else term_c = smx_pkg::pow2_frac(v_c[3:0]) >> v_c[8:4];
      sum_add = 23'(sum_ff) + 23'(term_c);
   end

   always_comb begin
      max_in = max_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (ctl.load && cnt_ff < smx_pkg::CntW'(smx_pkg::MaxEntries)) begin
         cnt_in = cnt_ff + 1'b1;
         if (logit > max_ff) max_in = logit;
      end
      if (v3_ff) sum_in = sum_add > 23'(smx_pkg::SumLimit) ? smx_pkg::SumLimit : sum_add[21:0];
      if (ctl.clear) begin
         max_in = {1'b1, {(smx_pkg::LogitW-1){1'b0}}};
         cnt_in = '0;
         sum_in = '0;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      q_in = q_ff;
      num_in = num_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh = {rem_ff[smx_pkg::SumW-1:0], num_ff[38]};
      if (ctl.div_start) begin
         num_in = 39'({6'd0, rd_term_ff, 16'd0} + 39'(sum_ff >> 1));
         rem_in = '0;
         q_in = '0;
         bit_in = 6'd39;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (rem_sh >= 23'(sum_ff)) begin
            rem_in = rem_sh - 23'(sum_ff);
            q_in = {q_ff[smx_pkg::QuotW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in = {q_ff[smx_pkg::QuotW-2:0], 1'b0};
         end
         bit_in = bit_ff - 1'b1;
         if (bit_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= {1'b1, {(smx_pkg::LogitW-1){1'b0}}};
         cnt_ff <= '0;
         sum_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         max_ff <= max_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         v1_ff <= exp_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      num_ff <= num_in;
      bit_ff <= bit_in;
      if (ctl.load && cnt_ff < smx_pkg::CntW'(smx_pkg::MaxEntries))
         logit_mem[cnt_ff[smx_pkg::IdxW-1:0]] <= logit;
      rd_logit_ff <= logit_mem[ctl.idx];
      widx_ff <= ctl.idx;
      t_ff <= max_ff - rd_logit_ff;
      widx2_ff <= widx_ff;
      widx3_ff <= widx2_ff;
      prod_ff <= 32'(t_ff) * 32'(smx_pkg::Log2eQ15);
      if (v3_ff) term_mem[widx3_ff] <= term_c;
      rd_term_ff <= term_mem[ctl.idx];
   end

   // exp pipeline: idx -> rd_logit (v1) -> t (v2) -> prod (v3) -> term write
   assign stat.count = cnt_ff;
   assign stat.div_done = done_ff;
   always_comb begin
      if (sum_ff == '0) quotient = '0;
      else if (q_ff > 17'd65535) quotient = 16'hFFFF;
      else quotient = q_ff[15:0];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/smx_ctrl.sv -----
// Softmax controller: load, exponent sweep, divide and emit sequencing.
// Depends on smx_pkg.
`default_nettype none
module smx_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_last,
   output logic req_ready,
   output logic rsp_valid,
   output logic rsp_last,
   input  wire logic rsp_ready,
   input  wire smx_pkg::stat_type stat,
   output smx_pkg::ctl_type ctl,
   output logic exp_valid
);
   typedef enum logic [2:0] {LOAD, EXPS, DRAIN, DIVS, DIVW, EMIT} state_type;
   state_type st_ff;
   logic [smx_pkg::CntW-1:0] idx_ff, n_ff;
   logic [2:0] drain_ff;
   logic acc;

   assign req_ready = (st_ff == LOAD);
   assign acc = req_valid && req_ready;
   assign rsp_valid = (st_ff == EMIT);
   assign rsp_last = (idx_ff + 1'b1 == n_ff);
   assign exp_valid = (st_ff == EXPS);
   always_comb begin
      ctl.load = acc;
      ctl.clear = (st_ff == EMIT) && rsp_ready && rsp_last;
      ctl.div_start = (st_ff == DIVS);
      ctl.idx = idx_ff[smx_pkg::IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= LOAD;
         idx_ff <= '0;
         n_ff <= '0;
         drain_ff <= '0;
      end else begin
         case (st_ff)
            LOAD: begin
               idx_ff <= '0;
               if (acc && req_last) begin
                  n_ff <= (stat.count < smx_pkg::CntW'(smx_pkg::MaxEntries))
                        ? stat.count + 1'b1 : stat.count;
                  st_ff <= EXPS;
               end
            end
            EXPS: begin
               if (idx_ff + 1'b1 == n_ff) begin
                  idx_ff <= '0;
                  drain_ff <= 3'd4;
                  st_ff <= DRAIN;
               end else idx_ff <= idx_ff + 1'b1;
            end
            DRAIN: begin
               drain_ff <= drain_ff - 1'b1;
               if (drain_ff == 3'd1) st_ff <= DIVS;
            end
            DIVS: st_ff <= DIVW;
            DIVW: if (stat.div_done) st_ff <= EMIT;
            EMIT: begin
               if (rsp_ready) begin
                  if (rsp_last) st_ff <= LOAD;
                  else begin
                     idx_ff <= idx_ff + 1'b1;
                     drain_ff <= 3'd1;
                     st_ff <= DRAIN;
                  end
               end
            end
            default: st_ff <= LOAD;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/softmax_normalizer_unit.sv -----
// Top level of the softmax normalizer: joins controller and datapath to the channels.
// Depends on smx_pkg, smx_if, smx_ctrl, smx_datapath.
`default_nettype none
// Logits load one beat a cycle while the controller is in its load state. The last
// beat starts a sweep over the stored logits and a pipeline drain computing exponent
// terms, then each probability passes through the one-bit-per-cycle restoring divider
// (start, 39 steps, done) before its beat is offered; each later probability first
// passes through the drain state to fetch its term. No new logits are taken until the
// last probability beat is accepted.
module softmax_normalizer_unit (
   input wire logic clock,
   input wire logic reset,
   smx_req_if.sink req,
   smx_rsp_if.source rsp
);
   smx_pkg::ctl_type ctl;
   smx_pkg::stat_type stat;
   logic exp_valid;

   smx_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_last(req.last_logit), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_last(rsp.last_probability), .rsp_ready(rsp.ready),
      .stat, .ctl, .exp_valid
   );

   smx_datapath u_dp (
      .clock, .reset, .ctl, .logit(req.logit), .exp_valid,
      .stat, .quotient(rsp.probability)
   );

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("load and emit overlap");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= smx_pkg::CntW'(smx_pkg::MaxEntries)) else $error("count overflow");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_probability |=> stat.count == '0)
      else $error("vector not cleared");
`endif
endmodule
`default_nettype wire

// ----- tb/softmax_normalizer_unit_test.sv -----
// Self-checking testbench for softmax_normalizer_unit: drives logit vectors, predicts
// max-subtracted fixed-point softmax probabilities and checks every result beat.
// Depends on smx_pkg, smx_if and the softmax_normalizer_unit RTL.
`default_nettype none
module softmax_normalizer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] logit;
      logic last_logit;
      int has_prob;
      logic [15:0] prob;
   } stim_row_type;

   typedef struct {
      logic [15:0] probability;
      logic last_probability;
   } prob_beat_type;

   localparam int CycleLimit = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycle_count = 0;
   int fail_count = 0;
   int send_idle_pct = 31;
   int recv_idle_pct = 73;

   smx_req_if req ();
   smx_rsp_if rsp ();

   softmax_normalizer_unit u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] vec_logits[smx_pkg::MaxEntries];
   logic signed [15:0] vec_max = -16'sd32768;
   int vec_count = 0;
   prob_beat_type prob_queue[$];
   int fixed_prob_queue[$];

   function automatic logic [16:0] exp_of_gap(logic signed [15:0] x, logic signed [15:0] mx);
      logic [15:0] t;
      logic [39:0] v;
      logic [3:0] frac_bits;
      int k;
      logic [16:0] tval;
      t = 16'(mx - x);
      v = (40'(t) * 40'd47274 + 40'd262144) >> 19;
      k = int'(v >> 4);
      frac_bits = v[3:0];
      case (frac_bits)
         4'd0: tval = 17'd65536;  4'd1: tval = 17'd62757;
         4'd2: tval = 17'd60097;  4'd3: tval = 17'd57549;
         4'd4: tval = 17'd55109;  4'd5: tval = 17'd52773;
         4'd6: tval = 17'd50535;  4'd7: tval = 17'd48393;
         4'd8: tval = 17'd46341;  4'd9: tval = 17'd44376;
         4'd10: tval = 17'd42495; 4'd11: tval = 17'd40693;
         4'd12: tval = 17'd38968; 4'd13: tval = 17'd37315;
         4'd14: tval = 17'd35734; default: tval = 17'd34219;
      endcase
      if (k >= 32) return 17'd0;
      return tval >> k;
   endfunction

   task automatic predict_logit(logic signed [15:0] x, logic last_in, int has_prob,
                                logic [15:0] fixed_prob);
      logic [16:0] terms[smx_pkg::MaxEntries];
      logic [23:0] sum;
      logic [47:0] p;
      prob_beat_type b;
      if (vec_count < smx_pkg::MaxEntries) begin
         vec_logits[vec_count] = x;
         vec_count++;
         if (x > vec_max) vec_max = x;
      end
      if (!last_in) return;
      sum = 0;
      for (int i = 0; i < vec_count; i++) begin
         terms[i] = exp_of_gap(vec_logits[i], vec_max);
         sum += 24'(terms[i]);
         if (sum > 24'(smx_pkg::SumLimit)) sum = 24'(smx_pkg::SumLimit);
      end
      for (int i = 0; i < vec_count; i++) begin
         p = 0;
         if (sum != 0) begin
            p = ((48'(terms[i]) << 16) + 48'(sum >> 1)) / 48'(sum);
            if (p > 48'd65535) p = 48'd65535;
         end
         b.probability = p[15:0];
         b.last_probability = (i + 1 == vec_count);
         prob_queue = {prob_queue, b};
         fixed_prob_queue = {fixed_prob_queue,
                             (has_prob && i + 1 == vec_count) ? int'(fixed_prob) : -1};
      end
      vec_max = -16'sd32768;
      vec_count = 0;
   endtask

   task automatic send_logit(logic signed [15:0] x, logic last_in, int has_prob = 0,
                             logic [15:0] fixed_prob = 16'd0);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.logit <= x;
      req.last_logit <= last_in;
      do @(posedge clock); while (!req.ready);
      predict_logit(x, last_in, has_prob, fixed_prob);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (prob_queue.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_vector();
      int n;
      logic signed [15:0] base;
      logic signed [15:0] x;
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 33) : $urandom_range(8, 1);
      base = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: x = 16'($urandom);
            1: x = base + 16'($urandom_range(511)) - 16'sd256;
            2: x = base;
            default: x = base - 16'($urandom_range(4095));
         endcase
         send_logit(x, i == n - 1);
      end
   endtask

   always @(posedge clock) begin
      prob_beat_type want;
      int fixed_prob;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (prob_queue.size() == 0) begin
            $error("probability beat with none expected: %0d", rsp.probability);
            fail_count++;
         end else begin
            want = prob_queue.pop_front();
            fixed_prob = fixed_prob_queue.pop_front();
            if (rsp.probability !== want.probability) begin
               $error("probability: expected %0d, got %0d", want.probability,
                      rsp.probability);
               fail_count++;
            end
            if (fixed_prob >= 0 && rsp.probability !== 16'(fixed_prob)) begin
               $error("probability: expected %0d, got %0d", fixed_prob, rsp.probability);
               fail_count++;
            end
            if (rsp.last_probability !== want.last_probability) begin
               $error("last_probability: expected %0b, got %0b", want.last_probability,
                      rsp.last_probability);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("softmax_normalizer_unit regression: fail");
         $finish;
      end
   end

   stim_row_type dir_rows[] = '{
      '{16'sd0, 1'b1, 1, 16'd65535},
      '{16'sh7fff, 1'b1, 1, 16'd65535},
      '{-16'sd32768, 1'b1, 1, 16'd65535},
      '{16'sd256, 1'b0, 0, 16'd0},
      '{16'sd256, 1'b1, 1, 16'd32768},
      '{-16'sd32768, 1'b0, 0, 16'd0},
      '{16'sh7fff, 1'b1, 1, 16'd65535},
      '{16'sd100, 1'b0, 0, 16'd0},
      '{-16'sd100, 1'b0, 0, 16'd0},
      '{16'sd0, 1'b0, 0, 16'd0},
      '{16'sh5555, 1'b0, 0, 16'd0},
      '{-16'sh5556, 1'b1, 0, 16'd0},
      '{16'sd1, 1'b0, 0, 16'd0},
      '{16'sd1, 1'b0, 0, 16'd0},
      '{16'sd1, 1'b0, 0, 16'd0},
      '{16'sd1, 1'b1, 1, 16'd16384}
   };

   initial begin
      req.valid = 1'b0;
      req.logit = '0;
      req.last_logit = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (dir_rows[i])
         send_logit(dir_rows[i].logit, dir_rows[i].last_logit, dir_rows[i].has_prob,
                    dir_rows[i].prob);
      // overflow the store: extra logits are dropped, even a larger one
      for (int i = 0; i < smx_pkg::MaxEntries; i++) send_logit(16'sd0, 1'b0);
      send_logit(16'sh7fff, 1'b0);
      send_logit(-16'sd5, 1'b1);
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 31 : 0;
         for (int v = 0; v < 16; v++) begin
            send_random_vector();
            if (v == 10) wait_drained();
         end
      end
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && prob_queue.size() == 0) begin
         $display("softmax_normalizer_unit regression: pass");
      end else begin
         $display("softmax_normalizer_unit regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/smx_pkg.sv
hw/rtl/smx_if.sv
hw/rtl/smx_datapath.sv
hw/rtl/smx_ctrl.sv
hw/rtl/softmax_normalizer_unit.sv
tb/softmax_normalizer_unit_test.sv
